FILE: rtl/core/vps_pkg.sv
// Shared types, constants and tables for the vehicle pose step block.
// Used by the register file, controller, datapath and top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vps_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int POS_WIDTH    = 40;
   localparam int CORDIC_STEPS = 16;
   localparam int MAX_STEPS    = 24;
   localparam int MOD_STEPS    = 24;
   localparam int IDX_BITS     = 5;

   localparam int DEAD_BAND = ((1 << FRAC_BITS) + 9) / 10;
   localparam int FULL_TURN = 360 << FRAC_BITS;

   localparam logic signed [33:0] GAIN_INV = 34'sd652032874;

   // Register indexes.
   localparam logic [1:0] REG_FWD   = 2'd0;
   localparam logic [1:0] REG_BWD   = 2'd1;
   localparam logic [1:0] REG_LEFT  = 2'd2;
   localparam logic [1:0] REG_RIGHT = 2'd3;

   // Operand selections of the shared multiplier.
   localparam logic [3:0] MUL_NOP = 4'd0;
   localparam logic [3:0] MUL_SPD = 4'd1;
   localparam logic [3:0] MUL_STR = 4'd2;
   localparam logic [3:0] MUL_T   = 4'd3;
   localparam logic [3:0] MUL_P   = 4'd4;
   localparam logic [3:0] MUL_Q   = 4'd5;
   localparam logic [3:0] MUL_R   = 4'd6;
   localparam logic [3:0] MUL_X   = 4'd7;
   localparam logic [3:0] MUL_Z   = 4'd8;

   typedef struct packed {
      logic signed [31:0] fwd;
      logic signed [31:0] bwd;
      logic signed [31:0] left;
      logic signed [31:0] right;
   } lim_type;

   typedef struct packed {
      logic                load;
      logic [3:0]          mul_op;
      logic                clamp;
      logic                cord_init;
      logic                cord_step;
      logic                mod_init;
      logic                mod_step;
      logic                finish;
      logic [IDX_BITS-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic opcode;
   } sts_type;

   // atan(2^-k) in degrees, Q8.24.
   function automatic logic [31:0] atan_deg(input logic [IDX_BITS-1:0] k);
      logic [31:0] r;
      case (k)
         5'd0:    r = 32'd754974720;
         5'd1:    r = 32'd445687602;
         5'd2:    r = 32'd235489088;
         5'd3:    r = 32'd119537938;
         5'd4:    r = 32'd60000934;
         5'd5:    r = 32'd30029717;
         5'd6:    r = 32'd15018523;
         5'd7:    r = 32'd7509720;
         5'd8:    r = 32'd3754917;
         5'd9:    r = 32'd1877466;
         5'd10:   r = 32'd938734;
         5'd11:   r = 32'd469367;
         5'd12:   r = 32'd234684;
         5'd13:   r = 32'd117342;
         5'd14:   r = 32'd58671;
         5'd15:   r = 32'd29335;
         5'd16:   r = 32'd14668;
         5'd17:   r = 32'd7334;
         5'd18:   r = 32'd3667;
         5'd19:   r = 32'd1833;
         5'd20:   r = 32'd917;
         5'd21:   r = 32'd458;
         5'd22:   r = 32'd229;
         5'd23:   r = 32'd115;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/vps_csr.sv
// Limit registers behind the APB-style configuration port.
// Depends on vps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vps_csr (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [3:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic      [31:0]        prdata,
   output logic                    pready,
   output vps_pkg::lim_type        lim
);

   vps_pkg::lim_type lim_ff, lim_in;
   logic [1:0] sel;

   assign sel    = paddr[3:2];
   assign pready = 1'b1;
   assign lim    = lim_ff;

   always_comb begin
      lim_in = lim_ff;
      if (psel && penable && pwrite) begin
         case (sel)
            vps_pkg::REG_FWD:   lim_in.fwd   = pwdata;
            vps_pkg::REG_BWD:   lim_in.bwd   = pwdata;
            vps_pkg::REG_LEFT:  lim_in.left  = pwdata;
            vps_pkg::REG_RIGHT: lim_in.right = pwdata;
            default:            lim_in = lim_ff;
         endcase
      end
   end

   always_comb begin
      case (sel)
         vps_pkg::REG_FWD:   prdata = lim_ff.fwd;
         vps_pkg::REG_BWD:   prdata = lim_ff.bwd;
         vps_pkg::REG_LEFT:  prdata = lim_ff.left;
         vps_pkg::REG_RIGHT: prdata = lim_ff.right;
         default:            prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff.fwd   <= 32'sd655360;
         lim_ff.bwd   <= -32'sd327680;
         lim_ff.left  <= 32'sd983040;
         lim_ff.right <= -32'sd983040;
      end else begin
         lim_ff <= lim_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/vps_ctrl.sv
// Sequencer of the pose step: walks the datapath through smoothing, CORDIC,
// shared-multiplier products and the heading wrap. Depends on vps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vps_ctrl #(
   parameter int CORDIC_STEPS = vps_pkg::CORDIC_STEPS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   input  wire vps_pkg::sts_type  sts,
   output vps_pkg::cmd_type       cmd
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_SM   = 4'd1;
   localparam logic [3:0] ST_ST   = 4'd2;
   localparam logic [3:0] ST_TS   = 4'd3;
   localparam logic [3:0] ST_PR   = 4'd4;
   localparam logic [3:0] ST_CI   = 4'd5;
   localparam logic [3:0] ST_QM   = 4'd6;
   localparam logic [3:0] ST_RM   = 4'd7;
   localparam logic [3:0] ST_CR   = 4'd8;
   localparam logic [3:0] ST_XM   = 4'd9;
   localparam logic [3:0] ST_ZM   = 4'd10;
   localparam logic [3:0] ST_MI   = 4'd11;
   localparam logic [3:0] ST_MD   = 4'd12;
   localparam logic [3:0] ST_FIN  = 4'd13;

   localparam logic [vps_pkg::IDX_BITS-1:0] CORD_LAST =
      vps_pkg::IDX_BITS'(CORDIC_STEPS - 1);
   localparam logic [vps_pkg::IDX_BITS-1:0] MOD_LAST =
      vps_pkg::IDX_BITS'(vps_pkg::MOD_STEPS - 1);

   logic [3:0] state_ff, state_in;
   logic [vps_pkg::IDX_BITS-1:0] idx_ff, idx_in;
   logic full_ff, full_in;
   logic take;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = full_ff;
   assign take      = full_ff && !rsp_stall;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      full_in  = take ? 1'b0 : full_ff;
      cmd      = '0;
      cmd.mul_op = vps_pkg::MUL_NOP;
      cmd.idx  = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SM;
            end
         end
         ST_SM: begin
            if (!sts.opcode) cmd.mul_op = vps_pkg::MUL_SPD;
            else cmd.clamp = 1'b1;
            state_in = ST_ST;
         end
         ST_ST: begin
            if (!sts.opcode) cmd.mul_op = vps_pkg::MUL_STR;
            state_in = ST_TS;
         end
         ST_TS: begin
            cmd.mul_op = vps_pkg::MUL_T;
            state_in = ST_PR;
         end
         ST_PR: begin
            cmd.mul_op = vps_pkg::MUL_P;
            state_in = ST_CI;
         end
         ST_CI: begin
            cmd.cord_init = 1'b1;
            state_in = ST_QM;
         end
         ST_QM: begin
            cmd.mul_op = vps_pkg::MUL_Q;
            state_in = ST_RM;
         end
         ST_RM: begin
            cmd.mul_op = vps_pkg::MUL_R;
            idx_in = '0;
            state_in = ST_CR;
         end
         ST_CR: begin
            cmd.cord_step = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == CORD_LAST) state_in = ST_XM;
         end
         ST_XM: begin
            cmd.mul_op = vps_pkg::MUL_X;
            state_in = ST_ZM;
         end
         ST_ZM: begin
            cmd.mul_op = vps_pkg::MUL_Z;
            state_in = ST_MI;
         end
         ST_MI: begin
            cmd.mod_init = 1'b1;
            idx_in = '0;
            state_in = ST_MD;
         end
         ST_MD: begin
            cmd.mod_step = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == MOD_LAST) state_in = ST_FIN;
         end
         ST_FIN: begin
            // The result register must be free before the new pose is shown.
            if (!full_ff || take) begin
               cmd.finish = 1'b1;
               full_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         full_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         full_ff  <= full_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/vps_dp.sv
// Datapath of the pose step: kept state, shared 34x34 multiplier, CORDIC
// iteration, restoring heading wrap and result register. Depends on vps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vps_dp (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire vps_pkg::cmd_type      cmd,
   input  wire vps_pkg::lim_type      lim,
   input  wire logic                  req_opcode,
   input  wire logic signed [31:0]    req_target_speed,
   input  wire logic signed [31:0]    req_target_steering,
   input  wire logic [16:0]           req_time_step,
   output vps_pkg::sts_type           sts,
   output logic signed [39:0]         rsp_out_x,
   output logic signed [39:0]         rsp_out_z,
   output logic [24:0]                rsp_out_heading,
   output logic signed [31:0]         rsp_out_speed,
   output logic signed [31:0]         rsp_out_steering
);

   localparam logic [1:0] MOD_KEEP = 2'd0;
   localparam logic [1:0] MOD_POS  = 2'd1;
   localparam logic [1:0] MOD_NEG  = 2'd2;

   localparam logic signed [34:0] ANG_90  = 35'sd1509949440;
   localparam logic signed [34:0] ANG_180 = 35'sd3019898880;
   localparam logic signed [34:0] ANG_270 = 35'sd4529848320;
   localparam logic signed [34:0] ANG_360 = 35'sd6039797760;
   localparam logic signed [51:0] FT52 = 52'(vps_pkg::FULL_TURN);
   localparam logic [24:0] FT25 = 25'(vps_pkg::FULL_TURN);
   localparam logic signed [31:0] DB = 32'(vps_pkg::DEAD_BAND);

   function automatic logic signed [31:0] bound(input logic signed [37:0] v,
                                                input logic signed [31:0] p,
                                                input logic signed [31:0] q);
      logic signed [37:0] lo;
      logic signed [37:0] hi;
      logic signed [37:0] r;
      lo = (p < q) ? 38'(p) : 38'(q);
      hi = (p < q) ? 38'(q) : 38'(p);
      r = v;
      if (r < lo) r = lo;
      if (r > hi) r = hi;
      return r[31:0];
   endfunction

   function automatic logic signed [31:0] dead(input logic signed [31:0] v);
      return (v > -DB && v < DB) ? 32'sd0 : v;
   endfunction

   logic                      opc_ff;
   logic signed [31:0]        tsp_ff, tst_ff;
   logic [16:0]               dt_ff;
   logic signed [31:0]        spd_ff, spd_in, str_ff, str_in;
   logic signed [39:0]        px_ff, px_in, pz_ff, pz_in;
   logic [24:0]               hdg_ff, hdg_in;
   logic signed [32:0]        t_ff, t_in;
   logic signed [47:0]        pr_ff, pr_in;
   logic signed [49:0]        acc_ff, acc_in;
   logic signed [33:0]        cx_ff, cx_in, cy_ff, cy_in;
   logic signed [34:0]        ang_ff, ang_in;
   logic                      flip_ff, flip_in;
   logic [49:0]               mv_ff, mv_in;
   logic [1:0]                mode_ff, mode_in;
   logic [3:0]                op_ff;
   logic signed [67:0]        prod_ff;
   logic signed [33:0]        mul_a, mul_b, co, si;
   logic signed [67:0]        w6;
   logic signed [37:0]        spd_sum, str_sum;
   logic signed [34:0]        ang0, atan_s;
   logic signed [51:0]        hsum, hneg;
   logic [49:0]               msh;
   logic [24:0]               hfin;
   logic signed [39:0]        step_pos;

   assign sts.opcode = opc_ff;
   assign co = flip_ff ? -cx_ff : cx_ff;
   assign si = flip_ff ? -cy_ff : cy_ff;

   always_comb begin
      case (cmd.mul_op)
         vps_pkg::MUL_SPD: begin
            mul_a = 34'(tsp_ff) - 34'(spd_ff);
            mul_b = $signed({17'd0, dt_ff});
         end
         vps_pkg::MUL_STR: begin
            mul_a = 34'(tst_ff) - 34'(str_ff);
            mul_b = $signed({17'd0, dt_ff});
         end
         vps_pkg::MUL_T: begin
            mul_a = 34'(spd_ff);
            mul_b = $signed({17'd0, dt_ff});
         end
         vps_pkg::MUL_P: begin
            mul_a = 34'(spd_ff);
            mul_b = 34'(str_ff);
         end
         vps_pkg::MUL_Q: begin
            mul_a = 34'($signed(pr_ff[47:16]));
            mul_b = $signed({17'd0, dt_ff});
         end
         vps_pkg::MUL_R: begin
            mul_a = $signed({18'd0, pr_ff[15:0]});
            mul_b = $signed({17'd0, dt_ff});
         end
         vps_pkg::MUL_X: begin
            mul_a = 34'(t_ff);
            mul_b = co;
         end
         vps_pkg::MUL_Z: begin
            mul_a = 34'(t_ff);
            mul_b = si;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Write-back of the product issued in the previous cycle.
   always_comb begin
      w6       = (prod_ff <<< 2) + (prod_ff <<< 1);
      spd_sum  = 38'(spd_ff) + $signed(prod_ff[51:14]);
      str_sum  = 38'(str_ff) + $signed(w6[53:16]);
      step_pos = {{2{prod_ff[67]}}, prod_ff[67:30]};
      spd_in = spd_ff;
      str_in = str_ff;
      px_in  = px_ff;
      pz_in  = pz_ff;
      t_in   = t_ff;
      pr_in  = pr_ff;
      acc_in = acc_ff;
      case (op_ff)
         vps_pkg::MUL_SPD: spd_in = bound(spd_sum, lim.bwd, lim.fwd);
         vps_pkg::MUL_STR: str_in = bound(str_sum, lim.left, lim.right);
         vps_pkg::MUL_T:   t_in   = prod_ff[48:16];
         vps_pkg::MUL_P:   pr_in  = prod_ff[63:16];
         vps_pkg::MUL_Q:   acc_in = prod_ff[49:0];
         vps_pkg::MUL_R:   acc_in = acc_ff + $signed({16'd0, prod_ff[49:16]});
         vps_pkg::MUL_X:   px_in  = px_ff + step_pos;
         vps_pkg::MUL_Z:   pz_in  = pz_ff + step_pos;
         default:          acc_in = acc_ff;
      endcase
      if (cmd.clamp) begin
         spd_in = bound(38'(spd_ff), lim.bwd, lim.fwd);
         str_in = bound(38'(str_ff), lim.left, lim.right);
      end
      if (cmd.finish) begin
         spd_in = dead(spd_ff);
         str_in = dead(str_ff);
      end
   end

   // CORDIC in rotation mode over degrees.
   always_comb begin
      ang0    = $signed({2'b00, hdg_ff, 8'd0});
      atan_s  = $signed({3'b000, vps_pkg::atan_deg(cmd.idx)});
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      ang_in  = ang_ff;
      flip_in = flip_ff;
      if (cmd.cord_init) begin
         cx_in   = vps_pkg::GAIN_INV;
         cy_in   = '0;
         flip_in = 1'b0;
         ang_in  = ang0;
         if (ang0 > ANG_270) begin
            ang_in = ang0 - ANG_360;
         end else if (ang0 > ANG_90) begin
            ang_in  = ang0 - ANG_180;
            flip_in = 1'b1;
         end
      end else if (cmd.cord_step) begin
         if (ang_ff >= 0) begin
            cx_in  = cx_ff - (cy_ff >>> cmd.idx);
            cy_in  = cy_ff + (cx_ff >>> cmd.idx);
            ang_in = ang_ff - atan_s;
         end else begin
            cx_in  = cx_ff + (cy_ff >>> cmd.idx);
            cy_in  = cy_ff - (cx_ff >>> cmd.idx);
            ang_in = ang_ff + atan_s;
         end
      end
   end

   // Heading wrap by restoring subtraction of the full turn, one shift a cycle.
   always_comb begin
      hsum    = 52'(acc_ff) + $signed({27'd0, hdg_ff});
      hneg    = -hsum;
      msh     = 50'(vps_pkg::FULL_TURN) << (5'd23 - cmd.idx);
      mv_in   = mv_ff;
      mode_in = mode_ff;
      if (cmd.mod_init) begin
         if (hsum > FT52) begin
            mode_in = MOD_POS;
            mv_in   = 50'(hsum - 52'sd1);
         end else if (hsum < 0) begin
            mode_in = MOD_NEG;
            mv_in   = hneg[49:0];
         end else begin
            mode_in = MOD_KEEP;
            mv_in   = hsum[49:0];
         end
      end else if (cmd.mod_step) begin
         if (mode_ff != MOD_KEEP && mv_ff >= msh) mv_in = mv_ff - msh;
      end
      case (mode_ff)
         MOD_POS:  hfin = mv_ff[24:0] + 25'd1;
         MOD_NEG:  hfin = (mv_ff == '0) ? 25'd0 : FT25 - mv_ff[24:0];
         default:  hfin = mv_ff[24:0];
      endcase
      hdg_in = cmd.finish ? hfin : hdg_ff;
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      t_ff    <= t_in;
      pr_ff   <= pr_in;
      acc_ff  <= acc_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      ang_ff  <= ang_in;
      flip_ff <= flip_in;
      mv_ff   <= mv_in;
      mode_ff <= mode_in;
      if (cmd.load) begin
         opc_ff <= req_opcode;
         tsp_ff <= req_target_speed;
         tst_ff <= req_target_steering;
         dt_ff  <= req_time_step;
      end
      if (cmd.finish) begin
         rsp_out_x        <= px_ff;
         rsp_out_z        <= pz_ff;
         rsp_out_heading  <= hfin;
         rsp_out_speed    <= spd_in;
         rsp_out_steering <= str_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff  <= vps_pkg::MUL_NOP;
         spd_ff <= '0;
         str_ff <= '0;
         px_ff  <= '0;
         pz_ff  <= '0;
         hdg_ff <= '0;
      end else begin
         op_ff  <= cmd.mul_op;
         spd_ff <= spd_in;
         str_ff <= str_in;
         px_ff  <= px_in;
         pz_ff  <= pz_in;
         hdg_ff <= hdg_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/vehicle_pose_step.sv
// Unicycle pose integrator: one request advances speed, steering, position
// and heading by one tick. Each request passes through the CORDIC iteration
// loop and the 24-step restoring heading wrap, which share one sequencer; a
// new request is taken only once the previous one has finished, while its
// result may still wait in the output register. Positions wrap at 40 bits,
// the heading lies in [0, 360] degrees, and limits may be written in either
// order.
// Depends on vps_pkg, vps_csr, vps_ctrl and vps_dp.
`timescale 1ns / 1ps
`default_nettype none
module vehicle_pose_step #(
   parameter int CORDIC_STEPS = vps_pkg::CORDIC_STEPS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_opcode,
   input  wire logic signed [31:0] req_target_speed,
   input  wire logic signed [31:0] req_target_steering,
   input  wire logic [16:0]        req_time_step,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [39:0]      rsp_out_x,
   output logic signed [39:0]      rsp_out_z,
   output logic [24:0]             rsp_out_heading,
   output logic signed [31:0]      rsp_out_speed,
   output logic signed [31:0]      rsp_out_steering,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [3:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   vps_pkg::lim_type lim;
   vps_pkg::cmd_type cmd;
   vps_pkg::sts_type sts;

   vps_csr u_csr (
      .clock(clock), .reset(reset), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
      .pready(pready), .lim(lim)
   );

   vps_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid),
      .req_stall(req_stall), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .sts(sts), .cmd(cmd)
   );

   vps_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .lim(lim),
      .req_opcode(req_opcode), .req_target_speed(req_target_speed),
      .req_target_steering(req_target_steering), .req_time_step(req_time_step),
      .sts(sts), .rsp_out_x(rsp_out_x), .rsp_out_z(rsp_out_z),
      .rsp_out_heading(rsp_out_heading), .rsp_out_speed(rsp_out_speed),
      .rsp_out_steering(rsp_out_steering)
   );

endmodule
`default_nettype wire

FILE: rtl/core/vps_checker.sv
// Port-level checks for vehicle_pose_step and the bind that attaches them.
// Depends on vehicle_pose_step.
`timescale 1ns / 1ps
`default_nettype none
module vps_port_checks (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic [24:0]        rsp_out_heading,
   input wire logic signed [31:0] rsp_out_speed,
   input wire logic signed [39:0] rsp_out_x
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_x))
      else $error("result dropped or changed while stalled");

   a_heading: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_heading <= 25'd23592960)
      else $error("heading outside the full turn");

   a_dead: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_speed == 32'sd0) || (rsp_out_speed >= 32'sd6554)
                    || (rsp_out_speed <= -32'sd6554))
      else $error("speed inside the dead band");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown after reset");

endmodule

bind vehicle_pose_step vps_port_checks u_vps_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_out_heading(rsp_out_heading), .rsp_out_speed(rsp_out_speed),
   .rsp_out_x(rsp_out_x)
);
`default_nettype wire

FILE: bench/vps_checker.sv
// Checker for the vehicle pose step block: watches the register port and both
// channels, predicts every result and compares it field by field.
// Depends on vps_pkg.
`timescale 1ns / 1ps
module vps_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_opcode,
   input  logic signed [31:0] req_target_speed,
   input  logic signed [31:0] req_target_steering,
   input  logic [16:0]        req_time_step,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [39:0] rsp_out_x,
   input  logic signed [39:0] rsp_out_z,
   input  logic [24:0]        rsp_out_heading,
   input  logic signed [31:0] rsp_out_speed,
   input  logic signed [31:0] rsp_out_steering,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   input  logic               pready,
   output int                 error_count,
   output int                 pending_count,
   output int                 result_count
);
   import vps_pkg::*;

   typedef struct packed {
      logic [39:0] x;
      logic [39:0] z;
      logic [24:0] heading;
      logic [31:0] speed;
      logic [31:0] steering;
   } pose_type;

   localparam longint ANG_SHIFT = 24 - FRAC_BITS;
   localparam longint TURN = longint'(FULL_TURN);

   longint arctan_q24 [0:23] = '{
      754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
      15018523, 7509720, 3754917, 1877466, 938734, 469367,
      234684, 117342, 58671, 29335, 14668, 7334,
      3667, 1833, 917, 458, 229, 115};

   longint lim_fwd, lim_bwd, lim_left, lim_right;
   longint speed_q, steer_q, head_q;
   logic [39:0] pos_x_q, pos_z_q;
   pose_type pose_queue[$];

   function automatic longint clamp_between(longint p, longint v, longint q);
      longint lo, hi;
      lo = (p < q) ? p : q;
      hi = (p < q) ? q : p;
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v;
   endfunction

   function automatic longint kill_small(longint v);
      return (v > -DEAD_BAND && v < DEAD_BAND) ? 0 : v;
   endfunction

   // Rotation-mode CORDIC over degrees; the middle half turn is folded with a
   // sign flip of both outputs.
   task automatic heading_trig(input longint h, output longint co, output longint si);
      longint ang, cx, cy, nx;
      bit flip;
      ang = h <<< ANG_SHIFT;
      cx = longint'(GAIN_INV);
      cy = 0;
      flip = 0;
      if (ang > (longint'(270) <<< 24)) ang -= longint'(360) <<< 24;
      else if (ang > (longint'(90) <<< 24)) begin
         ang -= longint'(180) <<< 24;
         flip = 1;
      end
      for (int k = 0; k < CORDIC_STEPS && k < 24; k++) begin
         if (ang >= 0) begin
            nx = cx - (cy >>> k);
            cy = cy + (cx >>> k);
            ang -= arctan_q24[k];
         end else begin
            nx = cx + (cy >>> k);
            cy = cy - (cx >>> k);
            ang += arctan_q24[k];
         end
         cx = nx;
      end
      co = flip ? -cx : cx;
      si = flip ? -cy : cy;
   endtask

   task automatic advance_pose(input logic opc, input longint tsp, input longint tst,
                               input longint dt, output pose_type p);
      longint co, si, t, prod, q, r, delta, sum;
      if (!opc) begin
         speed_q += ((tsp - speed_q) * dt * 4) >>> FRAC_BITS;
         steer_q += ((tst - steer_q) * dt * 6) >>> FRAC_BITS;
      end
      speed_q = clamp_between(lim_bwd, speed_q, lim_fwd);
      steer_q = clamp_between(lim_left, steer_q, lim_right);
      heading_trig(head_q, co, si);
      t = (speed_q * dt) >>> FRAC_BITS;
      pos_x_q = pos_x_q + 40'((t * co) >>> 30);
      pos_z_q = pos_z_q + 40'((t * si) >>> 30);
      // Split the product so the scaling by the time step cannot overflow.
      prod = (speed_q * steer_q) >>> FRAC_BITS;
      q = prod >>> FRAC_BITS;
      r = prod - (q <<< FRAC_BITS);
      delta = q * dt + ((r * dt) >>> FRAC_BITS);
      sum = head_q + delta;
      if (sum > TURN) sum = (sum - 1) % TURN + 1;
      else if (sum < 0) begin
         sum = sum % TURN;
         if (sum < 0) sum += TURN;
      end
      head_q = sum;
      speed_q = kill_small(speed_q);
      steer_q = kill_small(steer_q);
      p.x = pos_x_q;
      p.z = pos_z_q;
      p.heading = 25'(head_q);
      p.speed = 32'(speed_q);
      p.steering = 32'(steer_q);
   endtask

   assign pending_count = pose_queue.size();

   always @(posedge clock) begin
      pose_type got, want;
      if (reset) begin
         lim_fwd = 10 <<< FRAC_BITS;
         lim_bwd = -(5 <<< FRAC_BITS);
         lim_left = 15 <<< FRAC_BITS;
         lim_right = -(15 <<< FRAC_BITS);
         speed_q = 0;
         steer_q = 0;
         head_q = 0;
         pos_x_q = '0;
         pos_z_q = '0;
         pose_queue.delete();
         error_count = 0;
         result_count = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               REG_FWD:   lim_fwd = longint'(signed'(pwdata));
               REG_BWD:   lim_bwd = longint'(signed'(pwdata));
               REG_LEFT:  lim_left = longint'(signed'(pwdata));
               REG_RIGHT: lim_right = longint'(signed'(pwdata));
               default:   ;
            endcase
         end
         // The result transfer belongs to an older request, so it is checked
         // before a request on the same edge is predicted.
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_out_x, rsp_out_z, rsp_out_heading, rsp_out_speed,
                    rsp_out_steering};
            result_count++;
            if (pose_queue.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("ERROR: result with nothing expected: %h", got);
            end else begin
               want = pose_queue.pop_front();
               if (got !== want) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("ERROR: result %0d x %h/%h z %h/%h hdg %h/%h spd %h/%h str %h/%h",
                              result_count, want.x, got.x, want.z, got.z, want.heading,
                              got.heading, want.speed, got.speed, want.steering, got.steering);
               end
            end
         end
         if (req_valid && !req_stall) begin
            advance_pose(req_opcode, longint'(req_target_speed),
                         longint'(req_target_steering), longint'(req_time_step), want);
            pose_queue.insert(pose_queue.size(), want);
         end
      end
   end
endmodule

FILE: bench/tb_top.sv
// Top of the vehicle pose step testbench: clock, reset, register writes and
// request stimulus with random idling; the verdict uses the checker's count.
// Depends on vps_pkg, vehicle_pose_step and vps_checker.
`timescale 1ns / 1ps
module tb_top;
   import vps_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 80;

   logic clock, reset;
   logic req_valid, req_stall, req_opcode;
   logic signed [31:0] req_target_speed, req_target_steering;
   logic [16:0] req_time_step;
   logic rsp_valid, rsp_stall;
   logic signed [39:0] rsp_out_x, rsp_out_z;
   logic [24:0] rsp_out_heading;
   logic signed [31:0] rsp_out_speed, rsp_out_steering;
   logic psel, penable, pwrite, pready;
   logic [3:0] paddr;
   logic [31:0] pwdata, prdata;
   int error_count, pending_count, result_count;
   int send_idle_pct, recv_idle_pct, cycle_count;

   vehicle_pose_step u_top (.*);

   vps_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic write_limit(input logic [1:0] idx, input logic [31:0] value);
      @(posedge clock);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
   endtask

   task automatic set_limits(input logic [31:0] f, input logic [31:0] b,
                             input logic [31:0] l, input logic [31:0] r);
      write_limit(REG_FWD, f);
      write_limit(REG_BWD, b);
      write_limit(REG_LEFT, l);
      write_limit(REG_RIGHT, r);
   endtask

   task automatic drain;
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Drives one request and holds it until the transfer takes place.
   task automatic send_pose_req(input logic opc, input logic [31:0] sp,
                                input logic [31:0] st, input logic [16:0] dt);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         @(posedge clock);
         req_valid <= 0;
         repeat ($urandom_range(0, 3)) @(posedge clock);
      end
      @(posedge clock);
      req_valid <= 1;
      req_opcode <= opc;
      req_target_speed <= sp;
      req_target_steering <= st;
      req_time_step <= dt;
      do @(posedge clock); while (req_stall);
      req_valid <= 0;
   endtask

   task automatic send_random(input int count);
      logic [31:0] sp, st;
      logic [16:0] dt;
      for (int i = 0; i < count; i++) begin
         // Mostly plausible driving, with full-range words mixed in.
         if ($urandom_range(0, 9) < 7) begin
            sp = 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
            st = 32'($signed($urandom_range(0, 60 << 16)) - (30 << 16));
            dt = 17'($urandom_range(0, 16384));
         end else begin
            sp = $urandom;
            st = $urandom;
            dt = 17'($urandom_range(0, 131071));
         end
         if (i == count / 2) drain();
         send_pose_req($urandom_range(0, 3) == 0, sp, st, dt);
      end
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_opcode = 0;
      req_target_speed = 0;
      req_target_steering = 0;
      req_time_step = 0;
      psel = 0;
      penable = 0;
      pwrite = 0;
      paddr = 0;
      pwdata = 0;
      send_idle_pct = 20;
      recv_idle_pct = 61;
      repeat (8) @(posedge clock);
      reset <= 0;

      // Directed: default limits, extremes, deadzone edges, heading wrap.
      send_pose_req(0, 32'sh7fffffff, 32'sh7fffffff, 17'h10000);
      send_pose_req(1, 32'sh80000000, 32'sh80000000, 17'h1ffff);
      send_pose_req(0, 32'sh80000000, 32'sh7fffffff, 17'h1ffff);
      send_pose_req(0, 0, 0, 0);
      send_pose_req(0, 32'sd6554, 32'sd6554, 17'h04000);
      send_pose_req(1, 32'sd6553, -32'sd6553, 17'h04000);
      send_pose_req(0, -32'sd6554, -32'sd6554, 17'h10000);
      send_pose_req(0, 10 << 16, 15 << 16, 17'h10000);
      for (int i = 0; i < 6; i++) send_pose_req(1, 0, 0, 17'h10000);
      send_pose_req(0, -(5 << 16), -(15 << 16), 17'h10000);
      for (int i = 0; i < 6; i++) send_pose_req(1, 0, 0, 17'h1ffff);
      send_pose_req(0, 0, 0, 17'h10000);
      drain();

      send_random(170);
      drain();

      send_idle_pct = 61;
      recv_idle_pct = 20;
      // Limits written in reverse order.
      set_limits(-(3 << 16), 8 << 16, -(40 << 16), 40 << 16);
      send_random(170);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      // Full-range limits.
      set_limits(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
      send_random(170);
      drain();

      // Equal limits pin both values.
      set_limits(2 << 16, 2 << 16, 32'sd6000, 32'sd6000);
      send_random(100);
      drain();
      set_limits($urandom, $urandom, $urandom, $urandom);
      send_random(100);
      drain();

      $display("Covered %0d results over five limit settings, deadzone and heading wrap,",
               result_count);
      $display("with sender and receiver idling in turn and without idling.");
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches", error_count);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

FILE: filelist.f
rtl/core/vps_pkg.sv
rtl/core/vps_csr.sv
rtl/core/vps_ctrl.sv
rtl/core/vps_dp.sv
rtl/core/vehicle_pose_step.sv
rtl/core/vps_checker.sv
bench/vps_checker.sv
bench/tb_top.sv
